// ===== rtl/core/slpg_pkg.sv =====
// ----------------------------------------------------------------------------
// slpg_pkg
// Shared types and constants of the status LED pattern generator.
// ----------------------------------------------------------------------------
package slpg_pkg;

  localparam int TIME_WIDTH        = 32;
  localparam int REFRESH_PERIOD_MS = 40;

  localparam int DATA_PERIOD_MS   = 500;
  localparam int STROBE_HALF_MS   = 80;
  localparam int STROBE_LEN_MS    = 400;
  localparam int BOOT_LEN_MS      = 2500;
  localparam int BOOT_SLOT_MS     = 350;
  localparam int BOOT_ON_MS       = 200;
  localparam int HOME_HALF_MS     = 150;
  localparam int PKT_TIMEOUT_MS   = 1500;
  localparam int ID_CYCLE_MS      = 3000;
  localparam int ID_SLOT_MS       = 300;
  localparam int ID_ON_MS         = 180;

  localparam int M80_W   = $clog2(STROBE_HALF_MS);
  localparam int M150_W  = $clog2(HOME_HALF_MS);
  localparam int M500_W  = $clog2(DATA_PERIOD_MS);
  localparam int M350_W  = $clog2(BOOT_SLOT_MS);
  localparam int M300_W  = $clog2(ID_SLOT_MS);
  localparam int M3000_W = $clog2(ID_CYCLE_MS);
  localparam int BOOT_W  = $clog2(BOOT_LEN_MS);
  localparam int SPAN_W  = $clog2(ID_CYCLE_MS * 2);

  localparam int ID_W      = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-3:0] REG_BOARD_ID = '0;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [23:0]           colour_t;

  typedef struct packed {
    time_t                t;
    logic                 odd80;
    logic                 odd150;
    logic                 odd500;
    logic [M80_W-1:0]     mod80;
    logic [M150_W-1:0]    mod150;
    logic [M500_W-1:0]    mod500;
    logic [M350_W-1:0]    mod350;
    logic [M300_W-1:0]    mod300;
    logic [M3000_W-1:0]   mod3000;
  } phase_t;

  typedef struct packed {
    time_t last_error;
    time_t last_own;
    time_t last_master;
  } evt_times_t;

  localparam colour_t COL_OFF       = 24'h000000;
  localparam colour_t COL_RED       = {8'd255, 8'd0,   8'd0};
  localparam colour_t COL_CYAN      = {8'd0,   8'd200, 8'd200};
  localparam colour_t COL_AMBER     = {8'd180, 8'd140, 8'd0};
  localparam colour_t COL_ID_ON     = {8'd255, 8'd120, 8'd0};
  localparam colour_t COL_ID_OFF    = {8'd15,  8'd6,   8'd0};
  localparam colour_t COL_DIM_RED   = {8'd120, 8'd0,   8'd0};
  localparam colour_t COL_GREEN     = {8'd0,   8'd120, 8'd0};
  localparam colour_t COL_BLUE      = {8'd0,   8'd0,   8'd120};

endpackage

// ===== rtl/core/slpg_timebase.sv =====
// ----------------------------------------------------------------------------
// slpg_timebase
// Wrapping millisecond counter with running phase counters for each pattern.
// ----------------------------------------------------------------------------
module slpg_timebase import slpg_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   advance,
  output phase_t phase
);

  phase_t ph_r;
  phase_t ph_nxt;

  always_comb begin
    ph_nxt = ph_r;
    if (ph_r.t == {TIME_WIDTH{1'b1}}) begin
      ph_nxt = '0;
    end else begin
      ph_nxt.t = ph_r.t + TIME_WIDTH'(1);
      if (ph_r.mod80 == M80_W'(STROBE_HALF_MS - 1)) begin
        ph_nxt.mod80 = '0;
        ph_nxt.odd80 = ~ph_r.odd80;
      end else begin
        ph_nxt.mod80 = ph_r.mod80 + M80_W'(1);
      end
      if (ph_r.mod150 == M150_W'(HOME_HALF_MS - 1)) begin
        ph_nxt.mod150 = '0;
        ph_nxt.odd150 = ~ph_r.odd150;
      end else begin
        ph_nxt.mod150 = ph_r.mod150 + M150_W'(1);
      end
      if (ph_r.mod500 == M500_W'(DATA_PERIOD_MS - 1)) begin
        ph_nxt.mod500 = '0;
        ph_nxt.odd500 = ~ph_r.odd500;
      end else begin
        ph_nxt.mod500 = ph_r.mod500 + M500_W'(1);
      end
      if (ph_r.mod350 == M350_W'(BOOT_SLOT_MS - 1)) begin
        ph_nxt.mod350 = '0;
      end else begin
        ph_nxt.mod350 = ph_r.mod350 + M350_W'(1);
      end
      if (ph_r.mod300 == M300_W'(ID_SLOT_MS - 1)) begin
        ph_nxt.mod300 = '0;
      end else begin
        ph_nxt.mod300 = ph_r.mod300 + M300_W'(1);
      end
      if (ph_r.mod3000 == M3000_W'(ID_CYCLE_MS - 1)) begin
        ph_nxt.mod3000 = '0;
      end else begin
        ph_nxt.mod3000 = ph_r.mod3000 + M3000_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= '0;
    end else if (advance) begin
      ph_r <= ph_nxt;
    end
  end

  assign phase = ph_r;

endmodule

// ===== rtl/core/slpg_colour.sv =====
// ----------------------------------------------------------------------------
// slpg_colour
// Priority selection of the pixel colour for one refresh.
// ----------------------------------------------------------------------------
module slpg_colour import slpg_pkg::*; (
  input  phase_t          phase,
  input  evt_times_t      evt,
  input  logic [ID_W-1:0] board_id,
  input  logic            homing,
  input  logic            calibrated,
  output colour_t         colour
);

  logic [ID_W:0]   blinks;
  logic [SPAN_W-1:0] boot_span;
  logic [SPAN_W-1:0] id_span;
  time_t           err_dt;
  time_t           own_dt;
  time_t           master_dt;
  logic            strobe;
  logic            boot;
  logic            boot_on;
  logic            own_stale;
  logic            master_live;
  logic            id_on;

  always_comb begin
    blinks      = {1'b0, board_id} + (ID_W+1)'(1);
    boot_span   = SPAN_W'(blinks) * SPAN_W'(BOOT_SLOT_MS);
    id_span     = SPAN_W'(blinks) * SPAN_W'(ID_SLOT_MS);
    err_dt      = phase.t - evt.last_error;
    own_dt      = phase.t - evt.last_own;
    master_dt   = phase.t - evt.last_master;
    strobe      = err_dt < TIME_WIDTH'(STROBE_LEN_MS);
    boot        = phase.t < TIME_WIDTH'(BOOT_LEN_MS);
    boot_on     = (SPAN_W'(phase.t[BOOT_W-1:0]) < boot_span) &&
                  (phase.mod350 < M350_W'(BOOT_ON_MS));
    own_stale   = own_dt > TIME_WIDTH'(PKT_TIMEOUT_MS);
    master_live = (evt.last_master != '0) && (master_dt < TIME_WIDTH'(PKT_TIMEOUT_MS));
    id_on       = (SPAN_W'(phase.mod3000) < id_span) &&
                  (phase.mod300 < M300_W'(ID_ON_MS));

    if (strobe) begin
      colour = phase.odd80 ? COL_RED : COL_OFF;
    end else if (boot) begin
      colour = boot_on ? COL_CYAN : COL_OFF;
    end else if (homing) begin
      colour = phase.odd150 ? COL_AMBER : COL_OFF;
    end else if (own_stale) begin
      if (master_live) begin
        colour = id_on ? COL_ID_ON : COL_ID_OFF;
      end else begin
        colour = phase.odd500 ? COL_DIM_RED : COL_OFF;
      end
    end else begin
      colour = calibrated ? COL_GREEN : COL_BLUE;
    end
  end

endmodule

// ===== rtl/core/status_led_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_generator
// Millisecond tick driven data LED and RGB status pixel pattern generator.
// ----------------------------------------------------------------------------
// Each item passes the input reg, then the result reg, before its result is valid.
// One item per cycle while out_ready allows; event times register with each item.
// Reset clears the millisecond counter, event times, pending error, pixel
// colour and board_id; both pipeline stages come up empty.
// ----------------------------------------------------------------------------
module status_led_pattern_generator import slpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_error_seen,
  input  logic                  in_own_packet,
  input  logic                  in_master_packet,
  input  logic                  in_homing_or_calibrating,
  input  logic                  in_is_calibrated,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_traffic_led,
  output logic                  out_pixel_refresh,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic            board_sel;
  logic [ID_W-1:0] board_id_r;

  logic s1_valid_r;
  logic s1_err_r;
  logic s1_own_r;
  logic s1_master_r;
  logic s1_homing_r;
  logic s1_calib_r;

  logic       out_valid_r;
  logic       out_led_r;
  logic       out_refresh_r;
  colour_t    out_colour_r;

  time_t      last_refresh_r;
  evt_times_t evt_r;
  evt_times_t evt_nxt;
  logic       err_pending_r;
  logic       err_pending_nxt;
  colour_t    colour_r;
  colour_t    colour_nxt;
  colour_t    pick;

  phase_t     phase;
  logic       advance;
  logic       refresh;
  logic       pend_eff;
  time_t      refresh_dt;

  assign cfg_pready = 1'b1;
  assign board_sel  = cfg_paddr[CFG_ADDR_W-1:2] == REG_BOARD_ID;
  assign cfg_prdata = board_sel ? CFG_DATA_W'(board_id_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_id_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && board_sel) begin
      board_id_r <= cfg_pwdata[ID_W-1:0];
    end
  end

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  slpg_timebase u_timebase (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .phase   (phase)
  );

  always_comb begin
    refresh_dt = phase.t - last_refresh_r;
    refresh    = refresh_dt >= TIME_WIDTH'(REFRESH_PERIOD_MS);
    pend_eff   = err_pending_r | s1_err_r;
    evt_nxt    = evt_r;
    if (s1_own_r) begin
      evt_nxt.last_own = phase.t;
    end
    if (s1_master_r) begin
      evt_nxt.last_master = phase.t;
    end
    if (refresh && pend_eff) begin
      evt_nxt.last_error = phase.t;
    end
    err_pending_nxt = pend_eff && !refresh;
    colour_nxt      = refresh ? pick : colour_r;
  end

  slpg_colour u_colour (
    .phase      (phase),
    .evt        (evt_nxt),
    .board_id   (board_id_r),
    .homing     (s1_homing_r),
    .calibrated (s1_calib_r),
    .colour     (pick)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      last_refresh_r <= '0;
      evt_r          <= '0;
      err_pending_r  <= 1'b0;
      colour_r       <= COL_OFF;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r   <= 1'b1;
        evt_r         <= evt_nxt;
        err_pending_r <= err_pending_nxt;
        colour_r      <= colour_nxt;
        if (refresh) begin
          last_refresh_r <= phase.t;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_err_r    <= in_error_seen;
      s1_own_r    <= in_own_packet;
      s1_master_r <= in_master_packet;
      s1_homing_r <= in_homing_or_calibrating;
      s1_calib_r  <= in_is_calibrated;
    end
    if (advance) begin
      out_led_r     <= phase.odd500;
      out_refresh_r <= refresh;
      out_colour_r  <= colour_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_traffic_led   = out_led_r;
  assign out_pixel_refresh = out_refresh_r;
  assign out_red           = out_colour_r[23:16];
  assign out_green         = out_colour_r[15:8];
  assign out_blue          = out_colour_r[7:0];

`ifndef ASSERT_OFF
  a_refresh_time: assert property (@(posedge clk) disable iff (!rst_n)
    advance && refresh |=> last_refresh_r == $past(phase.t))
    else $error("refresh time not recorded");

  a_pending_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    advance && refresh |=> !err_pending_r)
    else $error("pending error survived a refresh");

  a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(phase.t))
    else $error("time moved without an item");

  a_colour_hold: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !refresh |=> $stable(colour_r))
    else $error("pixel changed without a refresh");
`endif

endmodule

// ===== verif/status_led_pattern_generator_checker.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_generator_checker
// Watches the tick, result and register ports of the status LED pattern
// generator, predicts the data LED and pixel colour for every accepted tick,
// and compares each accepted result field by field with the oldest prediction.
// Register reads are checked against the tracked board id.
// ----------------------------------------------------------------------------
module status_led_pattern_generator_checker import slpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_error_seen,
  input  logic                  in_own_packet,
  input  logic                  in_master_packet,
  input  logic                  in_homing_or_calibrating,
  input  logic                  in_is_calibrated,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_traffic_led,
  input  logic                  out_pixel_refresh,
  input  logic [7:0]            out_red,
  input  logic [7:0]            out_green,
  input  logic [7:0]            out_blue,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [CFG_DATA_W-1:0] cfg_prdata,
  input  logic                  cfg_pready,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic       led;
    logic       refresh;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } tick_status_t;

  tick_status_t queued_status[$];

  time_t       clock_ms;
  time_t       refresh_at;
  time_t       error_at;
  time_t       own_at;
  time_t       master_at;
  logic        error_latched;
  colour_t     shown_colour;
  logic [ID_W-1:0] id_reg;

  function automatic colour_t choose_colour(input time_t tick_ms, input logic homing,
                                            input logic calibrated);
    int unsigned blinks;
    time_t       since_error;
    time_t       since_own;
    time_t       since_master;
    time_t       slot;
    blinks       = id_reg + 1;
    since_error  = tick_ms - error_at;
    since_own    = tick_ms - own_at;
    since_master = tick_ms - master_at;
    if (since_error < STROBE_LEN_MS)
      return ((tick_ms / STROBE_HALF_MS) % 2 != 0) ? COL_RED : COL_OFF;
    if (tick_ms < BOOT_LEN_MS) begin
      if (tick_ms < blinks * BOOT_SLOT_MS && tick_ms % BOOT_SLOT_MS < BOOT_ON_MS)
        return COL_CYAN;
      return COL_OFF;
    end
    if (homing)
      return ((tick_ms / HOME_HALF_MS) % 2 != 0) ? COL_AMBER : COL_OFF;
    if (since_own > PKT_TIMEOUT_MS) begin
      // a master time of zero reads as no master seen
      if (master_at != 0 && since_master < PKT_TIMEOUT_MS) begin
        slot = tick_ms % ID_CYCLE_MS;
        if (slot < blinks * ID_SLOT_MS && slot % ID_SLOT_MS < ID_ON_MS)
          return COL_ID_ON;
        return COL_ID_OFF;
      end
      return ((tick_ms / DATA_PERIOD_MS) % 2 != 0) ? COL_DIM_RED : COL_OFF;
    end
    return calibrated ? COL_GREEN : COL_BLUE;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    time_t        tick_ms;
    time_t        since_refresh;
    tick_status_t want;
    tick_status_t made;
    if (!rst_n) begin
      clock_ms      = '0;
      refresh_at    = '0;
      error_at      = '0;
      own_at        = '0;
      master_at     = '0;
      error_latched = 1'b0;
      shown_colour  = COL_OFF;
      id_reg        = '0;
      mismatches    = 0;
      queued_status.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[CFG_ADDR_W-1:2] == REG_BOARD_ID) begin
        if (cfg_pwrite) begin
          id_reg = cfg_pwdata[ID_W-1:0];
        end else if (cfg_prdata !== CFG_DATA_W'(id_reg)) begin
          mismatches++;
          $display("%0t: board_id read mismatch, expected %0d, actual %0d",
                   $time, id_reg, cfg_prdata);
        end
      end

      if (out_valid && out_ready) begin
        if (queued_status.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, expected none, actual led=%0d rgb=%h",
                   $time, out_traffic_led, {out_red, out_green, out_blue});
        end else begin
          want = queued_status.pop_front();
          compare_field("traffic_led", 8'(want.led), 8'(out_traffic_led));
          compare_field("pixel_refresh", 8'(want.refresh), 8'(out_pixel_refresh));
          compare_field("red", want.red, out_red);
          compare_field("green", want.green, out_green);
          compare_field("blue", want.blue, out_blue);
        end
      end

      if (in_valid && in_ready) begin
        tick_ms = clock_ms;
        if (in_error_seen)
          error_latched = 1'b1;
        if (in_own_packet)
          own_at = tick_ms;
        if (in_master_packet)
          master_at = tick_ms;
        since_refresh = tick_ms - refresh_at;
        made.refresh  = 1'b0;
        if (since_refresh >= REFRESH_PERIOD_MS) begin
          made.refresh = 1'b1;
          refresh_at   = tick_ms;
          if (error_latched) begin
            error_latched = 1'b0;
            error_at      = tick_ms;
          end
          shown_colour = choose_colour(tick_ms, in_homing_or_calibrating, in_is_calibrated);
        end
        made.led   = (tick_ms / DATA_PERIOD_MS) % 2 != 0;
        made.red   = shown_colour[23:16];
        made.green = shown_colour[15:8];
        made.blue  = shown_colour[7:0];
        queued_status.push_back(made);
        clock_ms = tick_ms + 1;
      end
    end
    outstanding = queued_status.size();
  end

endmodule

// ===== verif/status_led_pattern_generator_tb.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_generator_tb
// Drives millisecond ticks with random event flags through the boot window of
// the pattern generator, walking the boot strobe, error strobes and power-on
// blink, changing board_id between phases, with random idling on both
// channels and a long result stall while ticks keep coming.
// ----------------------------------------------------------------------------
module status_led_pattern_generator_tb;
  import slpg_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [CFG_ADDR_W-1:0] BOARD_ID_ADDR = {REG_BOARD_ID, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR    = {~REG_BOARD_ID, 2'b00};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_error_seen;
  logic                  in_own_packet;
  logic                  in_master_packet;
  logic                  in_homing_or_calibrating;
  logic                  in_is_calibrated;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_traffic_led;
  logic                  out_pixel_refresh;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int mismatches;
  int outstanding;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;

  status_led_pattern_generator dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_error_seen            (in_error_seen),
    .in_own_packet            (in_own_packet),
    .in_master_packet         (in_master_packet),
    .in_homing_or_calibrating (in_homing_or_calibrating),
    .in_is_calibrated         (in_is_calibrated),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_traffic_led          (out_traffic_led),
    .out_pixel_refresh        (out_pixel_refresh),
    .out_red                  (out_red),
    .out_green                (out_green),
    .out_blue                 (out_blue),
    .cfg_psel                 (cfg_psel),
    .cfg_penable              (cfg_penable),
    .cfg_pwrite               (cfg_pwrite),
    .cfg_paddr                (cfg_paddr),
    .cfg_pwdata               (cfg_pwdata),
    .cfg_prdata               (cfg_prdata),
    .cfg_pready               (cfg_pready)
  );

  status_led_pattern_generator_checker u_check (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_error_seen            (in_error_seen),
    .in_own_packet            (in_own_packet),
    .in_master_packet         (in_master_packet),
    .in_homing_or_calibrating (in_homing_or_calibrating),
    .in_is_calibrated         (in_is_calibrated),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_traffic_led          (out_traffic_led),
    .out_pixel_refresh        (out_pixel_refresh),
    .out_red                  (out_red),
    .out_green                (out_green),
    .out_blue                 (out_blue),
    .cfg_psel                 (cfg_psel),
    .cfg_penable              (cfg_penable),
    .cfg_pwrite               (cfg_pwrite),
    .cfg_paddr                (cfg_paddr),
    .cfg_pwdata               (cfg_pwdata),
    .cfg_prdata               (cfg_prdata),
    .cfg_pready               (cfg_pready),
    .mismatches               (mismatches),
    .outstanding              (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[status_led_pattern_generator] ERROR");
    $finish;
  end

  initial begin : result_sink
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic logic chance(input int permille);
    return $urandom_range(0, 999) < permille;
  endfunction

  task automatic send_tick(input logic err, input logic own, input logic mst,
                           input logic homing, input logic cal);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0)
      gap = $urandom_range(1, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid                 <= 1'b1;
    in_error_seen            <= err;
    in_own_packet            <= own;
    in_master_packet         <= mst;
    in_homing_or_calibrating <= homing;
    in_is_calibrated         <= cal;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every predicted result has drained
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic run_phase(input int count, input logic [ID_W-1:0] id, input int err_pm,
                           input int own_pm, input int mst_pm, input int home_pm,
                           input int cal_pm);
    logic [CFG_DATA_W-1:0] word;
    settle();
    word            = $urandom;
    word[ID_W-1:0]  = id;
    cfg_access(1'b1, BOARD_ID_ADDR, word);
    cfg_access(1'b0, BOARD_ID_ADDR, '0);
    repeat (count)
      send_tick(chance(err_pm), chance(own_pm), chance(mst_pm), chance(home_pm),
                chance(cal_pm));
  endtask

  initial begin : stimulus
    rst_n                    <= 1'b0;
    in_valid                 <= 1'b0;
    in_error_seen            <= 1'b0;
    in_own_packet            <= 1'b0;
    in_master_packet         <= 1'b0;
    in_homing_or_calibrating <= 1'b0;
    in_is_calibrated         <= 1'b0;
    cfg_psel                 <= 1'b0;
    cfg_penable              <= 1'b0;
    cfg_pwrite               <= 1'b0;
    cfg_paddr                <= '0;
    cfg_pwdata               <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-ones write keeps only the id bits; the spare index is ignored
    cfg_access(1'b1, BOARD_ID_ADDR, '1);
    cfg_access(1'b1, SPARE_ADDR, '0);
    cfg_access(1'b0, BOARD_ID_ADDR, '0);

    // master packet at time zero, then every flag alone and all together
    send_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);

    // boot window: boot strobe, then power-on blink at several ids
    run_phase(400, '0, 2, 20, 0, 200, 500);
    // hold off results while ticks keep coming
    hold_request = 1'b1;
    repeat (100)
      send_tick(chance(2), chance(20), 1'b0, chance(200), chance(500));
    run_phase(400, '1, 2, 0, 0, 200, 500);
    run_phase(400, ID_W'($urandom_range(1, 14)), 2, 0, 30, 300, 500);
    run_phase(400, ID_W'($urandom), 2, 3, 30, 100, 500);
    calm = 1'b1;
    run_phase(300, '0, 3, 50, 20, 50, 500);
    settle();

    if (mismatches == 0 && outstanding == 0)
      $display("[status_led_pattern_generator] OK");
    else
      $display("[status_led_pattern_generator] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/slpg_pkg.sv
rtl/core/slpg_timebase.sv
rtl/core/slpg_colour.sv
rtl/core/status_led_pattern_generator.sv
verif/status_led_pattern_generator_checker.sv
verif/status_led_pattern_generator_tb.sv
